FILE: hdl/ray_annulus_intersect_core_assert.svh
// ----------------------------------------------------------------------------
// ray_annulus_intersect_core_assert.svh
// assertion macros shared by the annulus intersection core
// ----------------------------------------------------------------------------
`ifndef RAY_ANNULUS_INTERSECT_CORE_ASSERT_SVH
`define RAY_ANNULUS_INTERSECT_CORE_ASSERT_SVH

// same-cycle implication, checked on clk, off during rst
`define RAI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ray annulus core: same-cycle check failed");

// next-cycle implication, checked on clk, off during rst
`define RAI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ray annulus core: next-cycle check failed");

`endif

FILE: hdl/rai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_pkg
// shared widths, register codes, sideband type and saturation helper
// ----------------------------------------------------------------------------
package rai_pkg;

  localparam int CW         = 32;             // coordinate width
  localparam int FW         = 16;             // coordinate fraction bits
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 14;
  localparam int ROW_W      = 3 * COEF_W;
  localparam int RAD_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;
  localparam int PROD_W     = COEF_W + CW;
  localparam int SUM_W      = PROD_W + 2;
  localparam int WIDE_W     = 2 * CW + 2;
  localparam int DIVD_W     = CW + FW;        // dividend magnitude width
  localparam int DIV_STEPS  = DIVD_W;         // one quotient bit per stage

  localparam logic [ROW_W-1:0] ROW_X_RESET = ROW_W'(1) << COEF_FRAC;
  localparam logic [ROW_W-1:0] ROW_Y_RESET = ROW_W'(1) << (COEF_FRAC + COEF_W);
  localparam logic [ROW_W-1:0] ROW_Z_RESET = ROW_W'(1) << (COEF_FRAC + 2 * COEF_W);
  localparam logic [RAD_W-1:0] OUTER_RESET = RAD_W'(1) << FW;

  localparam logic signed [WIDE_W-1:0] COORD_MAX =
    {{(WIDE_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] COORD_MIN = ~COORD_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X    = 3'd0,
    CFG_ROW_Y    = 3'd1,
    CFG_ROW_Z    = 3'd2,
    CFG_OFFSET_X = 3'd3,
    CFG_OFFSET_Y = 3'd4,
    CFG_OFFSET_Z = 3'd5,
    CFG_OUTER    = 3'd6,
    CFG_HOLE     = 3'd7
  } cfg_idx_t;

  // values that ride alongside the divider
  typedef struct packed {
    logic signed [CW-1:0] lox;
    logic signed [CW-1:0] loz;
    logic signed [CW-1:0] ldx;
    logic signed [CW-1:0] ldz;
    logic signed [CW-1:0] near_t;
    logic signed [CW-1:0] far_t;
    logic                 ldy_zero;
  } side_t;

  function automatic logic signed [CW-1:0] clamp_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [CW-1:0] r;
    if (v > COORD_MAX) r = COORD_MAX[CW-1:0];
    else if (v < COORD_MIN) r = COORD_MIN[CW-1:0];
    else r = v[CW-1:0];
    return r;
  endfunction

endpackage

FILE: hdl/rai_xform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_xform
// two-stage affine transform of ray origin and direction into the disk frame
// ----------------------------------------------------------------------------
module rai_xform (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  logic signed [rai_pkg::CW-1:0]     origin_x,
  input  logic signed [rai_pkg::CW-1:0]     origin_y,
  input  logic signed [rai_pkg::CW-1:0]     origin_z,
  input  logic signed [rai_pkg::CW-1:0]     dir_x,
  input  logic signed [rai_pkg::CW-1:0]     dir_y,
  input  logic signed [rai_pkg::CW-1:0]     dir_z,
  input  logic signed [rai_pkg::CW-1:0]     near_limit,
  input  logic signed [rai_pkg::CW-1:0]     far_limit,
  input  logic [rai_pkg::ROW_W-1:0]         row_x_coeffs,
  input  logic [rai_pkg::ROW_W-1:0]         row_y_coeffs,
  input  logic [rai_pkg::ROW_W-1:0]         row_z_coeffs,
  input  logic signed [rai_pkg::CW-1:0]     offset_x,
  input  logic signed [rai_pkg::CW-1:0]     offset_y,
  input  logic signed [rai_pkg::CW-1:0]     offset_z,
  output logic                              xf_valid,
  output logic signed [rai_pkg::CW-1:0]     loy,
  output logic signed [rai_pkg::CW-1:0]     ldy,
  output rai_pkg::side_t                    xf_side
);

  logic signed [rai_pkg::CW-1:0]     vin [6];
  logic [rai_pkg::ROW_W-1:0]         rows [3];
  logic signed [rai_pkg::CW-1:0]     offs [3];
  logic signed [rai_pkg::PROD_W-1:0] prod_next [6][3];
  logic signed [rai_pkg::PROD_W-1:0] prod [6][3];
  logic signed [rai_pkg::CW-1:0]     near_a, far_a;
  logic                              valid_a;
  logic signed [rai_pkg::CW-1:0]     loc_next [6];

  assign vin[0] = origin_x;
  assign vin[1] = origin_y;
  assign vin[2] = origin_z;
  assign vin[3] = dir_x;
  assign vin[4] = dir_y;
  assign vin[5] = dir_z;
  assign rows[0] = row_x_coeffs;
  assign rows[1] = row_y_coeffs;
  assign rows[2] = row_z_coeffs;
  assign offs[0] = offset_x;
  assign offs[1] = offset_y;
  assign offs[2] = offset_z;

  // stage a: eighteen coefficient products
  // index o = vec*3 + row, vec 0 origin, vec 1 direction
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod_next[v*3 + r][k] =
            rai_pkg::PROD_W'($signed(rows[r][k*rai_pkg::COEF_W +: rai_pkg::COEF_W]))
            * rai_pkg::PROD_W'(vin[v*3 + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod   <= prod_next;
      near_a <= near_limit;
      far_a  <= far_limit;
    end
  end

  // stage b: row sum, floor shift, offset on the origin, saturate
  always_comb begin
    logic signed [rai_pkg::SUM_W-1:0]  s;
    logic signed [rai_pkg::WIDE_W-1:0] w;
    for (int o = 0; o < 6; o++) begin
      s = rai_pkg::SUM_W'(prod[o][0]) + rai_pkg::SUM_W'(prod[o][1])
        + rai_pkg::SUM_W'(prod[o][2]);
      w = rai_pkg::WIDE_W'(s >>> rai_pkg::COEF_FRAC);
      if (o < 3) w = w + rai_pkg::WIDE_W'(offs[o]);
      loc_next[o] = rai_pkg::clamp_coord(w);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      loy              <= loc_next[1];
      ldy              <= loc_next[4];
      xf_side.lox      <= loc_next[0];
      xf_side.loz      <= loc_next[2];
      xf_side.ldx      <= loc_next[3];
      xf_side.ldz      <= loc_next[5];
      xf_side.near_t   <= near_a;
      xf_side.far_t    <= far_a;
      xf_side.ldy_zero <= (loc_next[4] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a  <= 1'b0;
      xf_valid <= 1'b0;
    end else if (advance) begin
      valid_a  <= in_valid;
      xf_valid <= valid_a;
    end
  end

endmodule

FILE: hdl/rai_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_divider
// pipelined restoring divider for t = -loy * 2^16 / ldy, one bit per stage
// ----------------------------------------------------------------------------
module rai_divider (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  logic signed [rai_pkg::CW-1:0]     loy,
  input  logic signed [rai_pkg::CW-1:0]     ldy,
  input  rai_pkg::side_t                    in_side,
  output logic                              dv_valid,
  output logic [rai_pkg::DIVD_W-1:0]        quot,
  output logic                              quot_neg,
  output rai_pkg::side_t                    dv_side
);

  localparam int N = rai_pkg::DIV_STEPS;

  logic                          st_valid [N+1];
  logic [rai_pkg::CW-1:0]        st_rem   [N+1];
  logic [rai_pkg::DIVD_W-1:0]    st_dq    [N+1];
  logic [rai_pkg::CW-1:0]        st_den   [N+1];
  logic                          st_neg   [N+1];
  rai_pkg::side_t                st_side  [N+1];

  logic [rai_pkg::CW-1:0] mag_y, mag_d;

  assign mag_y = loy[rai_pkg::CW-1] ? rai_pkg::CW'(-loy) : rai_pkg::CW'(loy);
  assign mag_d = ldy[rai_pkg::CW-1] ? rai_pkg::CW'(-ldy) : rai_pkg::CW'(ldy);

  // stage 0: magnitudes and quotient sign
  always_ff @(posedge clk) begin
    if (advance) begin
      st_rem[0]  <= '0;
      st_dq[0]   <= {mag_y, {rai_pkg::FW{1'b0}}};
      st_den[0]  <= mag_d;
      st_neg[0]  <= (loy > 0) ^ ldy[rai_pkg::CW-1];
      st_side[0] <= in_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) st_valid[0] <= 1'b0;
    else if (advance) st_valid[0] <= in_valid;
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [rai_pkg::CW:0] r2, diff;
    logic                 ge;

    assign r2   = {st_rem[g], st_dq[g][rai_pkg::DIVD_W-1]};
    assign diff = r2 - {1'b0, st_den[g]};
    assign ge   = (r2 >= {1'b0, st_den[g]});

    always_ff @(posedge clk) begin
      if (advance) begin
        st_rem[g+1]  <= ge ? diff[rai_pkg::CW-1:0] : r2[rai_pkg::CW-1:0];
        st_dq[g+1]   <= {st_dq[g][rai_pkg::DIVD_W-2:0], ge};
        st_den[g+1]  <= st_den[g];
        st_neg[g+1]  <= st_neg[g];
        st_side[g+1] <= st_side[g];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) st_valid[g+1] <= 1'b0;
      else if (advance) st_valid[g+1] <= st_valid[g];
    end
  end

  assign dv_valid = st_valid[N];
  assign quot     = st_dq[N];
  assign quot_neg = st_neg[N];
  assign dv_side  = st_side[N];

endmodule

FILE: hdl/rai_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_hit
// t saturation, interval test, hit point, radius test and output register
// ----------------------------------------------------------------------------
module rai_hit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  logic                              in_valid,
  input  logic [rai_pkg::DIVD_W-1:0]        quot,
  input  logic                              quot_neg,
  input  rai_pkg::side_t                    in_side,
  input  logic [rai_pkg::RAD_W-1:0]         outer_radius,
  input  logic [rai_pkg::RAD_W-1:0]         hole_radius,
  output logic                              out_valid,
  output logic                              hit,
  output logic signed [rai_pkg::CW-1:0]     hit_distance,
  output logic signed [rai_pkg::CW-1:0]     local_x,
  output logic signed [rai_pkg::CW-1:0]     local_z
);

  localparam int SQ_W = 2 * rai_pkg::CW;
  localparam int R2_W = SQ_W + 1;

  // stage 1: signed, saturated t
  logic signed [rai_pkg::DIVD_W:0] qs;
  logic                            v1, ok1;
  logic signed [rai_pkg::CW-1:0]   t1;
  rai_pkg::side_t                  sd1;

  assign qs = quot_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk) begin
    if (advance) begin
      t1  <= rai_pkg::clamp_coord(rai_pkg::WIDE_W'(qs));
      ok1 <= !in_side.ldy_zero;
      sd1 <= in_side;
    end
  end

  // stage 2: interval test and t * direction
  logic                          v2, ok2;
  logic signed [rai_pkg::CW-1:0] t2, lox2, loz2;
  logic signed [SQ_W-1:0]        px2, pz2;

  always_ff @(posedge clk) begin
    if (advance) begin
      ok2  <= ok1 && (t1 >= sd1.near_t) && (t1 <= sd1.far_t);
      t2   <= t1;
      lox2 <= sd1.lox;
      loz2 <= sd1.loz;
      px2  <= SQ_W'(t1) * SQ_W'(sd1.ldx);
      pz2  <= SQ_W'(t1) * SQ_W'(sd1.ldz);
    end
  end

  // stage 3: hit point in the local frame
  logic                          v3, ok3;
  logic signed [rai_pkg::CW-1:0] t3, hx3, hz3;

  always_ff @(posedge clk) begin
    if (advance) begin
      ok3 <= ok2;
      t3  <= t2;
      hx3 <= rai_pkg::clamp_coord(rai_pkg::WIDE_W'(px2 >>> rai_pkg::FW)
                                  + rai_pkg::WIDE_W'(lox2));
      hz3 <= rai_pkg::clamp_coord(rai_pkg::WIDE_W'(pz2 >>> rai_pkg::FW)
                                  + rai_pkg::WIDE_W'(loz2));
    end
  end

  // stage 4: squares
  logic                          v4, ok4;
  logic signed [rai_pkg::CW-1:0] t4, hx4, hz4;
  logic [SQ_W-1:0]               sqx4, sqz4;
  logic [2*rai_pkg::RAD_W-1:0]   outer2, hole2;
  logic [rai_pkg::CW-1:0]        mx3, mz3;

  assign mx3 = hx3[rai_pkg::CW-1] ? rai_pkg::CW'(-hx3) : rai_pkg::CW'(hx3);
  assign mz3 = hz3[rai_pkg::CW-1] ? rai_pkg::CW'(-hz3) : rai_pkg::CW'(hz3);

  always_ff @(posedge clk) begin
    if (advance) begin
      ok4    <= ok3;
      t4     <= t3;
      hx4    <= hx3;
      hz4    <= hz3;
      sqx4   <= SQ_W'(mx3) * SQ_W'(mx3);
      sqz4   <= SQ_W'(mz3) * SQ_W'(mz3);
      outer2 <= (2*rai_pkg::RAD_W)'(outer_radius) * (2*rai_pkg::RAD_W)'(outer_radius);
      hole2  <= (2*rai_pkg::RAD_W)'(hole_radius) * (2*rai_pkg::RAD_W)'(hole_radius);
    end
  end

  // stage 5: radius test, zero fields on a miss
  logic [R2_W-1:0] r2;
  logic            hit_next;

  assign r2       = R2_W'(sqx4) + R2_W'(sqz4);
  assign hit_next = ok4 && (r2 < R2_W'(outer2)) && (r2 > R2_W'(hole2));

  always_ff @(posedge clk) begin
    if (advance) begin
      hit          <= hit_next;
      hit_distance <= hit_next ? t4  : '0;
      local_x      <= hit_next ? hx4 : '0;
      local_z      <= hit_next ? hz4 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

endmodule

FILE: hdl/ray_annulus_intersect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_annulus_intersect_core
// ray against a flat annulus in the local y = 0 plane, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   input channel in_valid/in_ready carries one ray per transfer: origin,
//   direction and the accepted t interval, all signed q16.16
//   output channel out_valid/out_ready returns one result per ray, in order:
//   hit flag, t and local x/z of the hit point (all zero on a miss)
//   configuration is a plain write port (cfg_write, cfg_index, cfg_data);
//   write only while no ray is in flight
//   the pipeline has 2 transform stages, 1 divider setup stage, 48 divider
//   stages (one quotient bit per stage) and 5 stages for t saturation,
//   interval, hit point, squares and radius test
//   throughput is one ray per cycle while no result is held
//   the whole pipeline advances together; when the receiver holds off a
//   waiting result, every stage holds and in_ready drops, and nothing is lost
//   reset (rst, synchronous) empties the pipeline and restores the identity
//   transform, zero offsets, outer radius 1.0 and no hole
// ----------------------------------------------------------------------------
module ray_annulus_intersect_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [rai_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rai_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rai_pkg::CW-1:0]        origin_x,
  input  logic signed [rai_pkg::CW-1:0]        origin_y,
  input  logic signed [rai_pkg::CW-1:0]        origin_z,
  input  logic signed [rai_pkg::CW-1:0]        dir_x,
  input  logic signed [rai_pkg::CW-1:0]        dir_y,
  input  logic signed [rai_pkg::CW-1:0]        dir_z,
  input  logic signed [rai_pkg::CW-1:0]        near_limit,
  input  logic signed [rai_pkg::CW-1:0]        far_limit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 hit,
  output logic signed [rai_pkg::CW-1:0]        hit_distance,
  output logic signed [rai_pkg::CW-1:0]        local_x,
  output logic signed [rai_pkg::CW-1:0]        local_z
);

`include "ray_annulus_intersect_core_assert.svh"

  // configuration registers
  logic [rai_pkg::ROW_W-1:0]     row_x_coeffs, row_y_coeffs, row_z_coeffs;
  logic signed [rai_pkg::CW-1:0] offset_x, offset_y, offset_z;
  logic [rai_pkg::RAD_W-1:0]     outer_radius, hole_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_coeffs <= rai_pkg::ROW_X_RESET;
      row_y_coeffs <= rai_pkg::ROW_Y_RESET;
      row_z_coeffs <= rai_pkg::ROW_Z_RESET;
      offset_x     <= '0;
      offset_y     <= '0;
      offset_z     <= '0;
      outer_radius <= rai_pkg::OUTER_RESET;
      hole_radius  <= '0;
    end else if (cfg_write) begin
      case (rai_pkg::cfg_idx_t'(cfg_index))
        rai_pkg::CFG_ROW_X:    row_x_coeffs <= cfg_data;
        rai_pkg::CFG_ROW_Y:    row_y_coeffs <= cfg_data;
        rai_pkg::CFG_ROW_Z:    row_z_coeffs <= cfg_data;
        rai_pkg::CFG_OFFSET_X: offset_x     <= cfg_data[rai_pkg::CW-1:0];
        rai_pkg::CFG_OFFSET_Y: offset_y     <= cfg_data[rai_pkg::CW-1:0];
        rai_pkg::CFG_OFFSET_Z: offset_z     <= cfg_data[rai_pkg::CW-1:0];
        rai_pkg::CFG_OUTER:    outer_radius <= cfg_data[rai_pkg::RAD_W-1:0];
        rai_pkg::CFG_HOLE:     hole_radius  <= cfg_data[rai_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // single pipeline enable: move whenever the output slot is free or drains
  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // transform into the disk frame
  logic                          xf_valid;
  logic signed [rai_pkg::CW-1:0] loy, ldy;
  rai_pkg::side_t                xf_side;

  rai_xform u_xform (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (in_valid),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .dir_z        (dir_z),
    .near_limit   (near_limit),
    .far_limit    (far_limit),
    .row_x_coeffs (row_x_coeffs),
    .row_y_coeffs (row_y_coeffs),
    .row_z_coeffs (row_z_coeffs),
    .offset_x     (offset_x),
    .offset_y     (offset_y),
    .offset_z     (offset_z),
    .xf_valid     (xf_valid),
    .loy          (loy),
    .ldy          (ldy),
    .xf_side      (xf_side)
  );

  // plane crossing distance
  logic                             dv_valid;
  logic [rai_pkg::DIVD_W-1:0]       quot;
  logic                             quot_neg;
  rai_pkg::side_t                   dv_side;

  rai_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (xf_valid),
    .loy      (loy),
    .ldy      (ldy),
    .in_side  (xf_side),
    .dv_valid (dv_valid),
    .quot     (quot),
    .quot_neg (quot_neg),
    .dv_side  (dv_side)
  );

  // interval, hit point and radius tests, output register
  rai_hit u_hit (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (dv_valid),
    .quot         (quot),
    .quot_neg     (quot_neg),
    .in_side      (dv_side),
    .outer_radius (outer_radius),
    .hole_radius  (hole_radius),
    .out_valid    (out_valid),
    .hit          (hit),
    .hit_distance (hit_distance),
    .local_x      (local_x),
    .local_z      (local_z)
  );

  // a miss carries all-zero fields
  `RAI_ASSERT_NOW(a_miss_zero, out_valid && !hit,
                  hit_distance == '0 && local_x == '0 && local_z == '0)
  // the input side only stalls behind a held result
  `RAI_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready)
  // a held result stays valid with its hit flag and distance unchanged
  `RAI_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready,
                   out_valid && $stable(hit) && $stable(hit_distance))

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ray / annulus intersection core
// ----------------------------------------------------------------------------
// a directed table covers the reset frame, the special cases and the field
// extremes. Random phases follow, each under a fresh transform and radii.
// Most rays are aimed at the disk, the rest are raw noise. Each result is
// compared by field with its typed row's answer or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb;

  localparam int CW         = rai_pkg::CW;
  localparam int FW         = rai_pkg::FW;
  localparam int COEF_FRAC  = rai_pkg::COEF_FRAC;
  localparam int ROW_W      = rai_pkg::ROW_W;
  localparam int RAD_W      = rai_pkg::RAD_W;
  localparam int CFG_IDX_W  = rai_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rai_pkg::CFG_DATA_W;

  localparam int LATENCY     = 56;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, dx, dy, dz, near_t, far_t;
  } ray_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] t, x, z;
  } isect_t;

  // one row of the directed table; typed rows carry their own answer
  typedef struct {
    ray_t   ray;
    bit     typed;
    isect_t want;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [CW-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [CW-1:0] near_limit = '0, far_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit;
  logic signed [CW-1:0] hit_distance, local_x, local_z;

  ray_annulus_intersect_core dut (.*);

  always #1 clk = ~clk;

  // shadow copy of the register file
  logic [ROW_W-1:0] frame_row [3];
  longint           frame_off [3];
  logic [RAD_W-1:0] rim_radius, hole_r;

  isect_t pending_isects [$];
  int     errors = 0;
  int     cycles = 0;
  int     rays_sent = 0;
  int     hits_seen = 0;
  int     settings_used = 0;
  int     hold_off = 0;   // long receiver stall, counted down by the receiver
  int     ready_mode = 0;

  // --------------------------------------------------------------------------
  // fixed-point predictor
  // --------------------------------------------------------------------------
  function automatic longint sat_coord(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // one matrix row applied to a point or vector, q2.14 coefficients
  function automatic longint xform_row(logic [ROW_W-1:0] row, longint a, longint b,
                                       longint c, longint off);
    longint ca, cb, cc, s;
    ca = longint'($signed(row[15:0]));
    cb = longint'($signed(row[31:16]));
    cc = longint'($signed(row[47:32]));
    s  = ca * a + cb * b + cc * c;
    return sat_coord((s >>> COEF_FRAC) + off);
  endfunction

  function automatic logic [63:0] mag_sq(longint v);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    return m * m;
  endfunction

  function automatic isect_t annulus_isect(ray_t r);
    isect_t res;
    longint lox, loy, loz, ldx, ldy, ldz, t, hx, hz;
    logic [63:0] r2, rim2, hole2;
    res = '{1'b0, '0, '0, '0};
    lox = xform_row(frame_row[0], r.ox, r.oy, r.oz, frame_off[0]);
    loy = xform_row(frame_row[1], r.ox, r.oy, r.oz, frame_off[1]);
    loz = xform_row(frame_row[2], r.ox, r.oy, r.oz, frame_off[2]);
    ldx = xform_row(frame_row[0], r.dx, r.dy, r.dz, 0);
    ldy = xform_row(frame_row[1], r.dx, r.dy, r.dz, 0);
    ldz = xform_row(frame_row[2], r.dx, r.dy, r.dz, 0);
    // parallel to the plane
    if (ldy == 0) return res;
    t = sat_coord((-loy * 65536) / ldy);
    if (t < longint'(r.near_t) || t > longint'(r.far_t)) return res;
    hx = sat_coord(((t * ldx) >>> FW) + lox);
    hz = sat_coord(((t * ldz) >>> FW) + loz);
    r2    = mag_sq(hx) + mag_sq(hz);
    rim2  = 64'(rim_radius) * 64'(rim_radius);
    hole2 = 64'(hole_r) * 64'(hole_r);
    // points on either circle miss
    if (r2 >= rim2 || r2 <= hole2) return res;
    res.hit = 1'b1;
    res.t   = t[CW-1:0];
    res.x   = hx[CW-1:0];
    res.z   = hz[CW-1:0];
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // register writes, called at a rising edge, return at the next one with
  // the write enable still high; the caller drops it after its last write
  // --------------------------------------------------------------------------
  task automatic write_reg(rai_pkg::cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      rai_pkg::CFG_ROW_X:    frame_row[0] = v;
      rai_pkg::CFG_ROW_Y:    frame_row[1] = v;
      rai_pkg::CFG_ROW_Z:    frame_row[2] = v;
      rai_pkg::CFG_OFFSET_X: frame_off[0] = longint'($signed(v[CW-1:0]));
      rai_pkg::CFG_OFFSET_Y: frame_off[1] = longint'($signed(v[CW-1:0]));
      rai_pkg::CFG_OFFSET_Z: frame_off[2] = longint'($signed(v[CW-1:0]));
      rai_pkg::CFG_OUTER:    rim_radius = v[RAD_W-1:0];
      rai_pkg::CFG_HOLE:     hole_r = v[RAD_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // kind 0: near identity, 1: raw noise, 2: extremes
  task automatic load_frame(int kind);
    logic [15:0] c [9];
    logic [31:0] o [3];
    logic [30:0] ro, rh;
    for (int i = 0; i < 9; i++) begin
      case (kind)
        0: c[i] = (i % 4 == 0) ? 16'(16384 + $urandom_range(0, 1600) - 800)
                               : 16'($urandom_range(0, 1200) - 600);
        1: c[i] = 16'($urandom);
        default: c[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      case (kind)
        0: o[i] = 32'($urandom_range(0, 65536) - 32768);
        1: o[i] = $urandom;
        default: o[i] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      endcase
    end
    case (kind)
      0: begin
        ro = 31'($urandom_range(32768, 8 << 16));
        rh = 31'($urandom_range(0, ro / 2));
      end
      1: begin
        ro = 31'($urandom);
        rh = 31'($urandom);
      end
      default: begin
        // full radius, hole either absent or as large as the rim
        ro = 31'h7fffffff;
        rh = $urandom_range(0, 1) ? 31'h7fffffff : 31'h0;
      end
    endcase
    write_reg(rai_pkg::CFG_ROW_X, {c[2], c[1], c[0]});
    write_reg(rai_pkg::CFG_ROW_Y, {c[5], c[4], c[3]});
    write_reg(rai_pkg::CFG_ROW_Z, {c[8], c[7], c[6]});
    write_reg(rai_pkg::CFG_OFFSET_X, 48'(o[0]));
    write_reg(rai_pkg::CFG_OFFSET_Y, 48'(o[1]));
    write_reg(rai_pkg::CFG_OFFSET_Z, 48'(o[2]));
    write_reg(rai_pkg::CFG_OUTER, 48'(ro));
    write_reg(rai_pkg::CFG_HOLE, 48'(rh));
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // input side: hold valid and payload until the transfer
  // --------------------------------------------------------------------------
  task automatic send_ray(ray_t r, bit typed, isect_t want);
    in_valid   <= 1'b1;
    origin_x   <= r.ox;
    origin_y   <= r.oy;
    origin_z   <= r.oz;
    dir_x      <= r.dx;
    dir_y      <= r.dy;
    dir_z      <= r.dz;
    near_limit <= r.near_t;
    far_limit  <= r.far_t;
    do @(posedge clk); while (!in_ready);
    pending_isects.push_back(typed ? want : annulus_isect(r));
    rays_sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // wait until every result is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_isects.size() != 0);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic ray_t noise_ray();
    ray_t r;
    r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom, $urandom};
    return r;
  endfunction

  // ray aimed at a point inside the rim, assuming a near identity frame
  function automatic ray_t aimed_ray();
    ray_t   r;
    longint span, tx, tz, t, d [3];
    span = longint'(rim_radius);
    if (span > (16 << 16)) span = 16 << 16;
    tx = longint'($urandom_range(0, 32'(span))) - span / 2;
    tz = longint'($urandom_range(0, 32'(span))) - span / 2;
    for (int i = 0; i < 3; i++) d[i] = longint'($urandom_range(0, 4 << 16)) - (2 << 16);
    if (d[1] > -16384 && d[1] < 16384) d[1] = $urandom_range(0, 1) ? 40000 : -40000;
    t = $urandom_range(0, 6 << 16);
    r.ox = 32'(tx - ((t * d[0]) >>> 16) - frame_off[0]);
    r.oy = 32'(-((t * d[1]) >>> 16) - frame_off[1]);
    r.oz = 32'(tz - ((t * d[2]) >>> 16) - frame_off[2]);
    r.dx = 32'(d[0]);
    r.dy = 32'(d[1]);
    r.dz = 32'(d[2]);
    case ($urandom_range(0, 9))
      0: begin r.near_t = 32'(t + 65536); r.far_t = 32'(t - 65536); end  // empty
      1: begin r.near_t = 32'(t + 8192); r.far_t = 32'h7fffffff; end     // too near
      default: begin
        r.near_t = 32'(t - $urandom_range(0, 3 << 16));
        r.far_t  = 32'(t + $urandom_range(0, 3 << 16));
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // receiver: changing stall pattern, plus the long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off  <= hold_off - 1;
    end else begin
      if ($urandom_range(0, 63) == 0) ready_mode <= $urandom_range(0, 3);
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) != 0);
        default: out_ready <= ((cycles % 7) < 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    isect_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_isects.size() == 0) begin
        report("unexpected result transfer", hit, 0);
      end else begin
        w = pending_isects.pop_front();
        if (hit !== w.hit) report("hit", hit, w.hit);
        if (hit_distance !== w.t) report("hit_distance", hit_distance, w.t);
        if (local_x !== w.x) report("local_x", local_x, w.x);
        if (local_z !== w.z) report("local_z", local_z, w.z);
        if (w.hit) hits_seen++;
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_isects.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // directed table
  // --------------------------------------------------------------------------
  localparam logic signed [CW-1:0] ONE  = 32'sd65536;
  localparam logic signed [CW-1:0] HALF = 32'sd32768;
  localparam logic signed [CW-1:0] MAXC = 32'sh7fffffff;
  localparam logic signed [CW-1:0] MINC = 32'sh80000000;
  localparam isect_t MISS = '{1'b0, '0, '0, '0};

  vec_t vectors [] = '{
    // straight down onto the reset disk
    '{'{HALF, ONE, 0, 0, -ONE, 0, 0, MAXC}, 1, '{1'b1, ONE, HALF, 0}},
    // parallel to the plane
    '{'{HALF, ONE, 0, ONE, 0, 0, MINC, MAXC}, 1, MISS},
    // empty interval
    '{'{HALF, ONE, 0, 0, -ONE, 0, ONE + 1, ONE}, 1, MISS},
    // t on both limits
    '{'{0, ONE, HALF, 0, -ONE, 0, ONE, ONE}, 1, '{1'b1, ONE, 0, HALF}},
    // t just past far
    '{'{HALF, ONE, 0, 0, -ONE, 0, 0, ONE - 1}, 1, MISS},
    // exactly on the rim
    '{'{ONE, ONE, 0, 0, -ONE, 0, 0, MAXC}, 1, MISS},
    // center equals the zero hole
    '{'{0, ONE, 0, 0, -ONE, 0, 0, MAXC}, 1, MISS},
    // t overflows and saturates, then extreme and mixed rays
    '{'{0, MAXC, 0, 0, -1, 0, 0, MAXC}, 0, MISS},
    '{'{0, MINC, 0, 0, -1, 0, MINC, MAXC}, 0, MISS},
    '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 0, MISS},
    '{'{MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC}, 0, MISS},
    '{'{MAXC, MINC, MAXC, MINC, MAXC, MINC, MINC, MAXC}, 0, MISS},
    '{'{MINC, 1, MINC, -1, MINC, 1, MINC, MAXC}, 0, MISS},
    '{'{-HALF, -ONE, -HALF, HALF, ONE, -HALF, MINC, MAXC}, 0, MISS},
    '{'{0, 3 * ONE, 0, HALF, -2 * ONE, -HALF, 0, 2 * ONE}, 0, MISS}
  };

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int burst, kind;
    bit relentless;
    frame_row[0] = rai_pkg::ROW_X_RESET;
    frame_row[1] = rai_pkg::ROW_Y_RESET;
    frame_row[2] = rai_pkg::ROW_Z_RESET;
    frame_off = '{0, 0, 0};
    rim_radius = rai_pkg::OUTER_RESET;
    hole_r = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows under the reset frame, then three rays with a hole
    foreach (vectors[i]) begin
      send_ray(vectors[i].ray, vectors[i].typed, vectors[i].want);
      idle_gap($urandom_range(0, 2));
    end
    drain();
    write_reg(rai_pkg::CFG_HOLE, 48'(HALF));
    cfg_write <= 1'b0;
    // inside the hole, exactly on the hole edge, then between hole and rim
    send_ray('{0, ONE, 16384, 0, -ONE, 0, 0, MAXC}, 1, MISS);
    send_ray('{HALF, ONE, 0, 0, -ONE, 0, 0, MAXC}, 1, MISS);
    send_ray('{0, ONE, 49152, 0, -ONE, 0, 0, MAXC}, 1, '{1'b1, ONE, 0, 49152});
    drain();

    // random phases, the extreme frames among them
    for (int phase = 0; phase < 10; phase++) begin
      kind = (phase == 3 || phase == 8) ? 2 : (phase == 5 ? 1 : 0);
      load_frame(kind);
      relentless = (phase == 4);
      if (relentless) hold_off = 300;   // receiver backs up the whole pipe
      burst = 0;
      for (int n = 0; n < 110; n++) begin
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          if (!relentless) idle_gap($urandom_range(0, 6));
        end
        burst--;
        send_ray(($urandom_range(0, 3) != 0) ? aimed_ray() : noise_ray(), 0, MISS);
      end
      drain();
    end

    $display("sent %0d rays over %0d register settings, %0d hits checked",
             rays_sent, settings_used, hits_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
